// File: rtl/utwm_pkg.sv
package utwm_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned BASE_W  = 10;
  localparam int unsigned METRIC_W = 8;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SUM_W   = 20;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_LOAD_INTERVAL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_GLYPH    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TEXT          = 2'd2;

  // UTF-8 lead byte classes and payload masks.
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD2_DATA = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_DATA = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_DATA = 8'h07;
  localparam logic [BYTE_W-1:0] CONT_DATA  = 8'h3F;

  localparam logic [SUM_W-1:0] WIDTH_MAX = 20'hFFFFF;

  // One interval table entry as stored in memory.
  typedef struct packed {
    logic [CP_W-1:0]   first;
    logic [CP_W-1:0]   last;
    logic [BASE_W-1:0] base;
  } interval_t;

  // One glyph metrics entry as stored in memory.
  typedef struct packed {
    logic [METRIC_W-1:0] advance;
    logic [METRIC_W-1:0] height;
  } glyph_t;

endpackage

// File: rtl/utwm_ram.sv
module utwm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/utf8_text_width_measure.sv
// UTF-8 text width measurement. Load items fill an interval table
// (code-point range and first glyph index) and a glyph metrics table;
// text items feed one UTF-8 byte each. An item is transferred when start
// is high while busy is low. A load item, a lead byte, or a continuation
// byte that does not finish a character leaves busy low. A byte that
// completes a code point, if interval_count is nonzero, keeps busy high
// while up to min(interval_count, MAX_INTERVALS) interval entries are
// scanned one per cycle through the single read port, first match wins; a
// hit inside the glyph table is accumulated. A zero byte ends the string:
// total_width_o and max_height_o appear for exactly one cycle with done_o
// high, in the cycle after the transfer, and the accumulators are cleared.
// The receiver cannot stall results and must take them when done_o is high.
// The table contents are undefined until written; there is no clearing pass
// after reset. The user must write interval_count via cfg_we_i and
// cfg_wdata_i only while idle; the block does not enforce it.
module utf8_text_width_measure
  import utwm_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = 32,
  parameter int unsigned MAX_GLYPHS    = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [SLOT_W-1:0]   entry_index_i,
  input  logic [CP_W-1:0]     range_first_i,
  input  logic [CP_W-1:0]     range_last_i,
  input  logic [BASE_W-1:0]   range_base_i,
  input  logic [METRIC_W-1:0] advance_in_i,
  input  logic [METRIC_W-1:0] height_in_i,
  input  logic [BYTE_W-1:0]   text_byte_i,
  input  logic                cfg_we_i,
  input  logic [5:0]          cfg_wdata_i,
  output logic                done_o,
  output logic [SUM_W-1:0]    total_width_o,
  output logic [METRIC_W-1:0] max_height_o
);

  localparam int unsigned IAW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned CW  = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned GAW = $clog2(MAX_GLYPHS);
  localparam int unsigned IDX_W = CP_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_GLYPH
  } state_e;

  state_e              state_q;
  logic [CW-1:0]       chk_q;
  logic [CP_W-1:0]     cp_q;
  logic [CP_W-1:0]     acc_q, acc_d;
  logic [1:0]          pend_q, pend_d;
  logic [SUM_W-1:0]    wsum_q;
  logic [METRIC_W-1:0] hmax_q;
  logic [5:0]          cfg_q;
  logic                done_q;
  logic [SUM_W-1:0]    tw_q;
  logic [METRIC_W-1:0] mh_q;

  logic            accept;
  logic            text_item;
  logic            end_of_string;
  logic            acct;
  logic [CP_W-1:0] acct_cp;
  logic [CP_W-1:0] shifted;
  logic [CW-1:0]   limit;
  logic [CW-1:0]   chk_nxt;

  interval_t        int_wdata, int_rdata;
  logic             int_we;
  logic [IAW-1:0]   int_raddr;
  glyph_t           gly_wdata, gly_rdata;
  logic             gly_we;
  logic [GAW-1:0]   gly_raddr;

  logic             hit;
  logic [CP_W-1:0]  offset;
  logic [IDX_W-1:0] gidx;
  logic             in_table;
  logic [SUM_W:0]   wsum_ext;
  logic [SUM_W-1:0] wsum_sat;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign text_item = accept && (kind_i == KIND_TEXT);
  assign end_of_string = text_item && (text_byte_i == '0);

  // Values of interval_count above the table size scan the whole table.
  always_comb begin
    if (32'(cfg_q) > 32'(MAX_INTERVALS)) begin
      limit = CW'(MAX_INTERVALS);
    end else begin
      limit = CW'(cfg_q);
    end
  end

  // UTF-8 decoder. Continuation bytes contribute their low six bits and
  // are not checked; stray bytes of 0x80 or above stand for themselves.
  assign shifted = {acc_q[CP_W-7:0], text_byte_i[5:0] & CONT_DATA[5:0]};

  always_comb begin
    acc_d   = acc_q;
    pend_d  = pend_q;
    acct    = 1'b0;
    acct_cp = CP_W'(text_byte_i);
    if (end_of_string) begin
      // A zero inside a multibyte character drops the partial character.
      acc_d  = '0;
      pend_d = '0;
    end else if (text_item) begin
      if (pend_q != '0) begin
        pend_d = pend_q - 2'd1;
        if (pend_q == 2'd1) begin
          acct    = 1'b1;
          acct_cp = shifted;
          acc_d   = '0;
        end else begin
          acc_d = shifted;
        end
      end else begin
        priority if ((text_byte_i & LEAD2_MASK) == LEAD2_CODE) begin
          acc_d  = CP_W'(text_byte_i & LEAD2_DATA);
          pend_d = 2'd1;
        end else if ((text_byte_i & LEAD3_MASK) == LEAD3_CODE) begin
          acc_d  = CP_W'(text_byte_i & LEAD3_DATA);
          pend_d = 2'd2;
        end else if ((text_byte_i & LEAD4_MASK) == LEAD4_CODE) begin
          acc_d  = CP_W'(text_byte_i & LEAD4_DATA);
          pend_d = 2'd3;
        end else begin
          acct = 1'b1;
        end
      end
    end
  end

  // Interval memory: written by load items, read once per scan cycle. The
  // transfer cycle launches the read of entry zero, and each scan cycle
  // launches the read of the entry after the one it checks.
  assign int_we          = accept && (kind_i == KIND_LOAD_INTERVAL)
                           && (32'(entry_index_i) < 32'(MAX_INTERVALS));
  assign int_wdata.first = range_first_i;
  assign int_wdata.last  = range_last_i;
  assign int_wdata.base  = range_base_i;
  assign chk_nxt         = chk_q + CW'(1);
  assign int_raddr       = (state_q == ST_IDLE) ? '0 : chk_nxt[IAW-1:0];

  utwm_ram #(
    .WIDTH ($bits(interval_t)),
    .DEPTH (MAX_INTERVALS)
  ) u_interval_ram (
    .clk_i   (clk_i),
    .we_i    (int_we),
    .waddr_i (entry_index_i[IAW-1:0]),
    .wdata_i (int_wdata),
    .raddr_i (int_raddr),
    .rdata_o (int_rdata)
  );

  // Match check on the entry that just came out of memory. A hit launches
  // the glyph read in the same cycle.
  assign hit      = (cp_q >= int_rdata.first) && (cp_q <= int_rdata.last);
  assign offset   = cp_q - int_rdata.first;
  assign gidx     = IDX_W'(int_rdata.base) + IDX_W'(offset);
  assign in_table = (gidx < IDX_W'(MAX_GLYPHS));
  assign gly_raddr = gidx[GAW-1:0];

  assign gly_we          = accept && (kind_i == KIND_LOAD_GLYPH)
                           && (32'(entry_index_i) < 32'(MAX_GLYPHS));
  assign gly_wdata.advance = advance_in_i;
  assign gly_wdata.height  = height_in_i;

  utwm_ram #(
    .WIDTH ($bits(glyph_t)),
    .DEPTH (MAX_GLYPHS)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (gly_we),
    .waddr_i (GAW'(entry_index_i)),
    .wdata_i (gly_wdata),
    .raddr_i (gly_raddr),
    .rdata_o (gly_rdata)
  );

  // Saturating width sum.
  assign wsum_ext = {1'b0, wsum_q} + (SUM_W + 1)'(gly_rdata.advance);
  assign wsum_sat = wsum_ext[SUM_W] ? WIDTH_MAX : wsum_ext[SUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chk_q   <= '0;
      cp_q    <= '0;
      acc_q   <= '0;
      pend_q  <= '0;
      wsum_q  <= '0;
      hmax_q  <= '0;
      cfg_q   <= '0;
      done_q  <= 1'b0;
      tw_q    <= '0;
      mh_q    <= '0;
    end else begin
      done_q <= 1'b0;
      acc_q  <= acc_d;
      pend_q <= pend_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (end_of_string) begin
            done_q <= 1'b1;
            tw_q   <= wsum_q;
            mh_q   <= hmax_q;
            wsum_q <= '0;
            hmax_q <= '0;
          end else if (acct && (limit != '0)) begin
            state_q <= ST_SCAN;
            chk_q   <= '0;
            cp_q    <= acct_cp;
          end
        end
        ST_SCAN: begin
          if (hit) begin
            state_q <= in_table ? ST_GLYPH : ST_IDLE;
          end else if (chk_nxt == limit) begin
            state_q <= ST_IDLE;
          end else begin
            chk_q <= chk_nxt;
          end
        end
        ST_GLYPH: begin
          wsum_q <= wsum_sat;
          if (gly_rdata.height > hmax_q) begin
            hmax_q <= gly_rdata.height;
          end
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o        = done_q;
  assign total_width_o = tw_q;
  assign max_height_o  = mh_q;

endmodule

// File: rtl/utwm_checker.sv
module utwm_checker
  import utwm_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic [KIND_W-1:0]   kind_i,
  input logic [BYTE_W-1:0]   text_byte_i,
  input logic                done_o,
  input logic [SUM_W-1:0]    total_width_o,
  input logic [METRIC_W-1:0] max_height_o
);

  logic acc_zero;
  logic acc_load;

  assign acc_zero = start && !busy && (kind_i == KIND_TEXT) && (text_byte_i == '0);
  assign acc_load = start && !busy
                    && ((kind_i == KIND_LOAD_INTERVAL) || (kind_i == KIND_LOAD_GLYPH));

  // The end of a string always yields a result in the next cycle.
  a_zero_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_zero |=> done_o)
    else $error("no result after end of string");

  // A result only ever follows the transfer of a zero text byte.
  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc_zero))
    else $error("result without end of string");

  // Load items never occupy the block beyond their transfer cycle.
  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_load |=> !busy)
    else $error("load item held the block busy");

  // Two ends of string in a row measure an empty string.
  a_empty_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(done_o)) |-> (total_width_o == '0 && max_height_o == '0))
    else $error("empty string gave a nonzero result");

endmodule

bind utf8_text_width_measure utwm_checker u_utwm_checker (.*);

// File: test/utf8_text_width_measure_tb.sv
module utf8_text_width_measure_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import utwm_pkg::*;

  localparam int unsigned NUM_INTERVALS = 32;
  localparam int unsigned NUM_GLYPHS    = 1024;
  localparam int unsigned RESET_CYCLES  = 5;
  // A completed code point scans at most NUM_INTERVALS entries and then may read its
  // glyph, so this many quiet cycles leave the block idle.
  localparam int unsigned DRAIN_CYCLES  = NUM_INTERVALS + 8;
  // Longest quiet stretch of a correct run: a sender gap, a full scan, or a drain
  // pause. The watchdog allows many times that.
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [CP_W-1:0]   CP_MAX      = 21'h1FFFFF;

  // One input item, with every field the block has.
  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   slot;
    logic [CP_W-1:0]     first;
    logic [CP_W-1:0]     last;
    logic [BASE_W-1:0]   base;
    logic [METRIC_W-1:0] adv;
    logic [METRIC_W-1:0] hgt;
    logic [BYTE_W-1:0]   tbyte;
  } measure_item_t;

  // One measured string: what the block reports on a terminating zero byte.
  typedef struct {
    logic [SUM_W-1:0]    width;
    logic [METRIC_W-1:0] height;
  } measure_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [KIND_W-1:0]   kind_i;
  logic [SLOT_W-1:0]   entry_index_i;
  logic [CP_W-1:0]     range_first_i;
  logic [CP_W-1:0]     range_last_i;
  logic [BASE_W-1:0]   range_base_i;
  logic [METRIC_W-1:0] advance_in_i;
  logic [METRIC_W-1:0] height_in_i;
  logic [BYTE_W-1:0]   text_byte_i;
  logic                cfg_we_i;
  logic [5:0]          cfg_wdata_i;
  logic                done_o;
  logic [SUM_W-1:0]    total_width_o;
  logic [METRIC_W-1:0] max_height_o;

  utf8_text_width_measure i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .entry_index_i (entry_index_i),
    .range_first_i (range_first_i),
    .range_last_i  (range_last_i),
    .range_base_i  (range_base_i),
    .advance_in_i  (advance_in_i),
    .height_in_i   (height_in_i),
    .text_byte_i   (text_byte_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .total_width_o (total_width_o),
    .max_height_o  (max_height_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state. It mirrors the tables, the UTF-8 decoder and the two
  // accumulators. glyph_loaded tracks which glyph slots hold defined metrics, so
  // that the stimulus never makes the block read a slot that was never written.
  // ---------------------------------------------------------------------------
  interval_t           interval_tab [NUM_INTERVALS];
  glyph_t              glyph_tab    [NUM_GLYPHS];
  bit                  glyph_loaded [NUM_GLYPHS];
  logic [CP_W-1:0]     code_acc    = '0;
  int unsigned         bytes_left  = 0;
  logic [SUM_W-1:0]    width_acc   = '0;
  logic [METRIC_W-1:0] height_acc  = '0;
  logic [5:0]          scan_count  = '0;

  // Strings that have been terminated but whose measurement has not come out yet.
  measure_t            pending_measures [$];

  int                  errors = 0;
  int                  idle_pct;
  int unsigned         stall_cycles = 0;

  // First-match scan of the scanned part of the interval table. Returns 1 when the
  // code point maps to a glyph slot inside the table; idx is that slot.
  function automatic bit find_glyph(input logic [CP_W-1:0] cp, output int unsigned idx);
    int unsigned lim;
    int unsigned i;
    lim = (scan_count > NUM_INTERVALS) ? NUM_INTERVALS : scan_count;
    idx = 0;
    for (i = 0; i < lim; i++) begin
      if (cp >= interval_tab[i].first && cp <= interval_tab[i].last) begin
        idx = interval_tab[i].base + (cp - interval_tab[i].first);
        return idx < NUM_GLYPHS;
      end
    end
    return 1'b0;
  endfunction

  // Adds one decoded code point to the running width and height.
  function automatic void add_code_point(input logic [CP_W-1:0] cp);
    int unsigned idx;
    logic [SUM_W:0] sum;
    if (find_glyph(cp, idx)) begin
      sum = width_acc + glyph_tab[idx].advance;
      width_acc = (sum > WIDTH_MAX) ? WIDTH_MAX : sum[SUM_W-1:0];
      if (glyph_tab[idx].height > height_acc) begin
        height_acc = glyph_tab[idx].height;
      end
    end
  endfunction

  // Tells whether a text byte would finish a code point, without changing state.
  function automatic bit completes_code_point(input logic [BYTE_W-1:0] b,
                                              output logic [CP_W-1:0] cp);
    cp = CP_W'(b);
    if (b == '0) begin
      return 1'b0;
    end
    if (bytes_left != 0) begin
      cp = {code_acc[CP_W-7:0], b[5:0]};
      return bytes_left == 1;
    end
    if ((b & LEAD2_MASK) == LEAD2_CODE || (b & LEAD3_MASK) == LEAD3_CODE ||
        (b & LEAD4_MASK) == LEAD4_CODE) begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Applies one transferred item to the predictor and queues the measurement
  // that a zero byte produces.
  function automatic void update_measure(input measure_item_t it);
    measure_t m;
    case (it.kind)
      KIND_LOAD_INTERVAL: begin
        if (it.slot < NUM_INTERVALS) begin
          interval_tab[it.slot].first = it.first;
          interval_tab[it.slot].last  = it.last;
          interval_tab[it.slot].base  = it.base;
        end
      end
      KIND_LOAD_GLYPH: begin
        glyph_tab[it.slot].advance = it.adv;
        glyph_tab[it.slot].height  = it.hgt;
        glyph_loaded[it.slot]      = 1'b1;
      end
      KIND_TEXT: begin
        if (it.tbyte == '0) begin
          // The string ends here; a partial character is simply dropped.
          m.width  = width_acc;
          m.height = height_acc;
          pending_measures.push_back(m);
          code_acc   = '0;
          bytes_left = 0;
          width_acc  = '0;
          height_acc = '0;
        end else if (bytes_left != 0) begin
          // Continuation bytes give their low six bits; the top bits are not checked.
          code_acc = {code_acc[CP_W-7:0], it.tbyte[5:0]};
          bytes_left--;
          if (bytes_left == 0) begin
            add_code_point(code_acc);
            code_acc = '0;
          end
        end else if ((it.tbyte & LEAD2_MASK) == LEAD2_CODE) begin
          code_acc   = CP_W'(it.tbyte & LEAD2_DATA);
          bytes_left = 1;
        end else if ((it.tbyte & LEAD3_MASK) == LEAD3_CODE) begin
          code_acc   = CP_W'(it.tbyte & LEAD3_DATA);
          bytes_left = 2;
        end else if ((it.tbyte & LEAD4_MASK) == LEAD4_CODE) begin
          code_acc   = CP_W'(it.tbyte & LEAD4_DATA);
          bytes_left = 3;
        end else begin
          // ASCII and stray bytes of 0x80 or above stand for themselves.
          add_code_point(CP_W'(it.tbyte));
        end
      end
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Item construction. Fields that an item kind does not use are random, so the
  // block is also shown that it ignores them.
  // ---------------------------------------------------------------------------
  function automatic measure_item_t random_fields();
    measure_item_t it;
    it.kind  = KIND_W'($urandom);
    it.slot  = SLOT_W'($urandom);
    it.first = CP_W'($urandom);
    it.last  = CP_W'($urandom);
    it.base  = BASE_W'($urandom);
    it.adv   = METRIC_W'($urandom);
    it.hgt   = METRIC_W'($urandom);
    it.tbyte = BYTE_W'($urandom);
    return it;
  endfunction

  function automatic measure_item_t interval_item(input logic [SLOT_W-1:0] slot,
                                                  input logic [CP_W-1:0] first,
                                                  input logic [CP_W-1:0] last,
                                                  input logic [BASE_W-1:0] base);
    measure_item_t it;
    it       = random_fields();
    it.kind  = KIND_LOAD_INTERVAL;
    it.slot  = slot;
    it.first = first;
    it.last  = last;
    it.base  = base;
    return it;
  endfunction

  function automatic measure_item_t glyph_item(input logic [SLOT_W-1:0] slot,
                                               input logic [METRIC_W-1:0] adv,
                                               input logic [METRIC_W-1:0] hgt);
    measure_item_t it;
    it      = random_fields();
    it.kind = KIND_LOAD_GLYPH;
    it.slot = slot;
    it.adv  = adv;
    it.hgt  = hgt;
    return it;
  endfunction

  // An interval in one of the UTF-8 length classes, or anywhere. Some are empty,
  // and some have a base close enough to the top that part of them runs off the
  // glyph table.
  function automatic measure_item_t random_interval_item(input logic [SLOT_W-1:0] slot);
    int unsigned lo;
    int unsigned hi;
    int unsigned first;
    int unsigned span;
    logic [CP_W-1:0] last;
    logic [BASE_W-1:0] base;
    case ($urandom_range(4, 0))
      0:       begin lo = 'h0;     hi = 'h7F;     end
      1:       begin lo = 'h80;    hi = 'h7FF;    end
      2:       begin lo = 'h800;   hi = 'hFFFF;   end
      3:       begin lo = 'h10000; hi = CP_MAX;   end
      default: begin lo = 'h0;     hi = CP_MAX;   end
    endcase
    first = $urandom_range(hi, lo);
    span  = ($urandom_range(3, 0) == 0) ? $urandom_range(2000, 0) : $urandom_range(60, 0);
    if (first != 0 && $urandom_range(9, 0) == 0) begin
      last = CP_W'($urandom_range(first - 1, 0));
    end else begin
      last = CP_W'((first + span > CP_MAX) ? CP_MAX : first + span);
    end
    base = ($urandom_range(5, 0) == 0) ? BASE_W'($urandom_range(1023, 1000))
                                       : BASE_W'($urandom_range(1023, 0));
    return interval_item(slot, CP_W'(first), last, base);
  endfunction

  // A continuation byte: usually the well-formed 10xxxxxx pattern, sometimes with
  // random top bits, never zero since a zero would end the string.
  function automatic logic [BYTE_W-1:0] cont_byte(input logic [31:0] bits);
    logic [BYTE_W-1:0] b;
    b = {2'b10, bits[5:0]};
    if ($urandom_range(4, 0) == 0) begin
      b[7:6] = 2'($urandom);
    end
    if (b == '0) begin
      b = 8'h80;
    end
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving. Inputs change just after a falling edge; an item is transferred at
  // the rising edge where start is high and busy is low. Each task returns just
  // after a falling edge with start low.
  // ---------------------------------------------------------------------------
  task automatic send_item(input measure_item_t it);
    if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      repeat ($urandom_range(17, 1)) @(negedge clk_i);
    end
    kind_i        = it.kind;
    entry_index_i = it.slot;
    range_first_i = it.first;
    range_last_i  = it.last;
    range_base_i  = it.base;
    advance_in_i  = it.adv;
    height_in_i   = it.hgt;
    text_byte_i   = it.tbyte;
    start         = 1'b1;
    do @(posedge clk_i); while (busy);
    update_measure(it);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  // Sends one text byte. If that byte finishes a code point that hits a glyph
  // slot still holding undefined metrics, the slot is loaded first; a load in the
  // middle of a character leaves the decoder alone.
  task automatic send_text(input logic [BYTE_W-1:0] b);
    measure_item_t it;
    logic [CP_W-1:0] cp;
    int unsigned idx;
    if (completes_code_point(b, cp)) begin
      if (find_glyph(cp, idx) && !glyph_loaded[idx]) begin
        send_item(glyph_item(SLOT_W'(idx), METRIC_W'($urandom), METRIC_W'($urandom)));
      end
    end
    it       = random_fields();
    it.kind  = KIND_TEXT;
    it.tbyte = b;
    send_item(it);
  endtask

  // Waits until every terminated string has been reported, then lets the longest
  // scan run out so that the block is idle.
  task automatic wait_idle();
    while (pending_measures.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_scan_count(input logic [5:0] count);
    wait_idle();
    cfg_wdata_i = count;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    scan_count  = count;
  endtask

  // One well-formed character, mostly taken from an interval that is scanned so
  // that it hits, and encoded in its shortest form or, now and then, overlong.
  task automatic send_random_char();
    int unsigned lim;
    int unsigned j;
    int unsigned minb;
    int unsigned nbytes;
    int k;
    logic [31:0] cp;
    logic [BYTE_W-1:0] lead;
    lim = (scan_count > NUM_INTERVALS) ? NUM_INTERVALS : scan_count;
    j   = (lim != 0) ? $urandom_range(lim - 1, 0) : 0;
    if (lim != 0 && $urandom_range(3, 0) != 0 &&
        interval_tab[j].first <= interval_tab[j].last) begin
      cp = interval_tab[j].first +
           $urandom_range(interval_tab[j].last - interval_tab[j].first, 0);
    end else begin
      case ($urandom_range(3, 0))
        0:       cp = $urandom_range('h7F, 1);
        1:       cp = $urandom_range('h7FF, 'h80);
        2:       cp = $urandom_range('hFFFF, 'h800);
        default: cp = $urandom_range(CP_MAX, 'h10000);
      endcase
    end
    if (cp == 0) begin
      minb = 2;
    end else begin
      minb = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
    end
    nbytes = ($urandom_range(4, 0) == 0) ? $urandom_range(4, minb) : minb;
    if (nbytes == 1) begin
      send_text(BYTE_W'(cp));
    end else begin
      case (nbytes)
        2:       lead = LEAD2_CODE | (BYTE_W'(cp >> 6) & LEAD2_DATA);
        3:       lead = LEAD3_CODE | (BYTE_W'(cp >> 12) & LEAD3_DATA);
        default: lead = LEAD4_CODE | (BYTE_W'(cp >> 18) & LEAD4_DATA);
      endcase
      send_text(lead);
      for (k = nbytes - 1; k > 0; k--) begin
        send_text(cont_byte(cp >> (6 * (k - 1))));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Right after reset the interval count is zero, so nothing is scanned and the
  // unwritten tables are never touched: every string measures zero.
  task automatic test_unscanned_text();
    send_text(8'h41);
    send_text(8'hC3);
    send_text(8'hA9);
    send_text(8'h00);
    send_text(8'h00);
  endtask

  // Loads a hand-made interval table and walks through the corner cases: field
  // extremes, every item kind, all UTF-8 lengths, stray bytes, an empty interval,
  // glyph slots past the table with a later interval that would have matched, a
  // zero inside a character, an empty string and loads in the middle of text.
  task automatic test_directed_cases();
    measure_item_t it;
    int unsigned i;
    send_item(interval_item(10'd0, 21'h41, 21'h40, 10'h000));    // empty interval
    send_item(interval_item(10'd1, 21'h20, 21'h7F, 10'h000));    // ASCII
    send_item(interval_item(10'd2, 21'h80, 21'hFF, 10'h3F0));    // mostly past the table
    send_item(interval_item(10'd3, 21'h100, 21'h7FF, 10'h100));
    send_item(interval_item(10'd4, 21'h2000, 21'h20FF, 10'h200));
    send_item(interval_item(10'd5, 21'h1F600, CP_MAX, 10'h300));
    send_item(interval_item(10'd6, 21'h0, 21'h1F, 10'h000));     // controls and NUL
    send_item(interval_item(10'd7, 21'h41, 21'hFF, 10'h010));    // shadowed by 1 and 2
    for (i = 8; i < NUM_INTERVALS; i++) begin
      send_item(random_interval_item(SLOT_W'(i)));
    end
    write_scan_count(6'd32);

    send_item(glyph_item(10'h3FF, 8'hFF, 8'hFF));
    send_item(glyph_item(10'h000, 8'h00, 8'h00));
    // A slot past the interval table is ignored.
    send_item(interval_item(10'h3FF, CP_MAX, CP_MAX, 10'h3FF));
    // The unused kind with every field at its top is ignored too.
    it       = interval_item(10'h3FF, CP_MAX, CP_MAX, 10'h3FF);
    it.kind  = KIND_UNUSED;
    it.adv   = 8'hFF;
    it.hgt   = 8'hFF;
    it.tbyte = 8'hFF;
    send_item(it);

    send_text(8'h41);                                 // skips the empty interval
    send_text(8'hC3);
    send_item(glyph_item(10'h005, 8'h07, 8'h09));     // load inside a character
    send_text(8'hA9);                                 // U+00E9 lands past the table
    send_text(8'h8F);                                 // stray byte, last glyph slot
    send_text(8'hE2);
    send_text(8'h82);
    send_text(8'hAC);                                 // U+20AC
    send_text(8'hF0);
    send_text(8'h9F);
    send_text(8'h98);
    send_text(8'h80);                                 // U+1F600
    send_text(8'h00);
    send_text(8'hE2);
    send_text(8'h82);
    send_text(8'h00);                                 // ends mid-character
    send_text(8'h00);                                 // empty string
    send_text(8'hFF);
    send_text(8'hF8);
    send_text(8'hC0);
    send_text(8'h80);                                 // overlong NUL is a code point
    send_text(8'h00);
  endtask

  // A long run of the widest glyph builds up a large width sum.
  task automatic test_long_string();
    idle_pct = 0;
    send_item(glyph_item(10'h3FF, 8'hFF, 8'h80));
    send_item(interval_item(10'd0, 21'h41, 21'h41, 10'h3FF));
    write_scan_count(6'd1);
    repeat (200) send_text(8'h41);
    send_text(8'h00);
  endtask

  // Random text over a random interval table, in phases with different scan
  // counts and sender gap rates. Most of it is well-formed characters; the rest
  // is stray or truncating bytes, table reloads and ignored items. The last two
  // phases run without gaps.
  task automatic test_random_text();
    int unsigned phase_count [10] = '{63, 32, 1, 0, 33, 0, 8, 31, 0, 32};
    int          phase_pct   [10] = '{0, 25, 50, 10, 35, 60, 15, 40, 0, 0};
    int unsigned i;
    int unsigned n;
    int unsigned r;
    logic [5:0] count;
    measure_item_t it;
    idle_pct = 0;
    for (i = 0; i < NUM_INTERVALS; i++) begin
      send_item(random_interval_item(SLOT_W'(i)));
    end
    for (i = 0; i < 10; i++) begin
      count = (i == 5 || i == 8) ? 6'($urandom) : 6'(phase_count[i]);
      write_scan_count(count);
      idle_pct = phase_pct[i];
      for (n = 0; n < 36; n++) begin
        r = $urandom_range(99, 0);
        if (r < 66) begin
          send_random_char();
        end else if (r < 78) begin
          send_text(8'h00);
        end else if (r < 86) begin
          send_text(BYTE_W'($urandom_range(255, 1)));
        end else if (r < 92) begin
          send_item(glyph_item(SLOT_W'($urandom), METRIC_W'($urandom), METRIC_W'($urandom)));
        end else if (r < 97) begin
          send_item(random_interval_item(($urandom_range(7, 0) == 0)
                                         ? SLOT_W'($urandom)
                                         : SLOT_W'($urandom_range(31, 0))));
        end else begin
          it      = random_fields();
          it.kind = KIND_UNUSED;
          send_item(it);
        end
      end
      send_text(8'h00);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking. A measurement is valid for exactly one cycle, so every cycle
  // with done_o high is compared against the oldest terminated string.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    measure_t want;
    if (rst_ni && done_o) begin
      if (pending_measures.size() == 0) begin
        errors++;
        $display("%0t ns: measurement with no string pending: width %0d height %0d",
                 $time, total_width_o, max_height_o);
      end else begin
        want = pending_measures.pop_front();
        if (total_width_o !== want.width) begin
          errors++;
          $display("%0t ns: total_width expected %0d, got %0d",
                   $time, want.width, total_width_o);
        end
        if (max_height_o !== want.height) begin
          errors++;
          $display("%0t ns: max_height expected %0d, got %0d",
                   $time, want.height, max_height_o);
        end
      end
    end
  end

  // Watchdog: any transfer on either side restarts the count of quiet cycles.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    kind_i        = '0;
    entry_index_i = '0;
    range_first_i = '0;
    range_last_i  = '0;
    range_base_i  = '0;
    advance_in_i  = '0;
    height_in_i   = '0;
    text_byte_i   = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    idle_pct      = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_unscanned_text();
    test_directed_cases();
    test_long_string();
    test_random_text();

    wait_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: utf8_text_width_measure.f
rtl/utwm_pkg.sv
rtl/utwm_ram.sv
rtl/utf8_text_width_measure.sv
rtl/utwm_checker.sv
test/utf8_text_width_measure_tb.sv
